// ===== design/kvs_pkg.sv =====
package kvs_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned AlphaWidth = 17;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_CMP,
      ST_KEY_RD,
      ST_KEY_WAIT,
      ST_KEY0,
      ST_KEY1,
      ST_DIV,
      ST_BLEND,
      ST_DONE
   } state_type;

   // control between the sequencer and the serial blend unit
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } blend_ctl_type;

endpackage

// ===== design/kvs_req_if.sv =====
interface kvs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [9:0]  key_index;
   logic [31:0] key_time;
   logic [31:0] key_x;
   logic [31:0] key_y;
   logic [31:0] key_z;
   logic [31:0] key_w;
   logic [9:0]  chan_first;
   logic [10:0] chan_count;
   logic        step_mode;
   logic [31:0] sample_time;

   modport source (output valid, command, key_index, key_time, key_x, key_y, key_z,
      key_w, chan_first, chan_count, step_mode, sample_time, input ready);
   modport sink (input valid, command, key_index, key_time, key_x, key_y, key_z,
      key_w, chan_first, chan_count, step_mode, sample_time, output ready);
endinterface

// ===== design/kvs_rsp_if.sv =====
interface kvs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic [31:0] out_w;
   logic [9:0]  segment_found;
   logic [1:0]  status;

   modport source (output valid, out_x, out_y, out_z, out_w, segment_found, status,
      input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, segment_found, status,
      output ready);
endinterface

// ===== design/kvs_ram.sv =====
module kvs_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/kvs_blend.sv =====
// bit-serial a + floor((b - a) * alpha / 2^16) for four lanes at once,
// shift-add over the 17 alpha bits, lsb first
module kvs_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [16:0]          alpha,
   input  logic [4*32-1:0]      val_a,
   input  logic [4*32-1:0]      val_b,
   output kvs_pkg::blend_ctl_type ctl,
   output logic [4*32-1:0]      result
);
   localparam int unsigned Lanes = 4;

   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] alpha_ff, alpha_in;
   logic signed [32:0] diff_ff [Lanes];
   logic signed [32:0] diff_in [Lanes];
   // accumulator holds sum of partial products scaled by 2^-count
   logic signed [51:0] acc_ff [Lanes];
   logic signed [51:0] acc_in [Lanes];
   logic [31:0] base_ff [Lanes];
   logic [31:0] base_in [Lanes];
   logic [4*32-1:0] result_ff, result_in;

   always_comb begin
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      alpha_in  = alpha_ff;
      result_in = result_ff;
      for (int i = 0; i < Lanes; i++) begin
         diff_in[i] = diff_ff[i];
         acc_in[i]  = acc_ff[i];
         base_in[i] = base_ff[i];
      end
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         alpha_in = alpha;
         for (int i = 0; i < Lanes; i++) begin
            base_in[i] = val_a[i*32 +: 32];
            diff_in[i] = {val_b[i*32+31], val_b[i*32 +: 32]}
               - {val_a[i*32+31], val_a[i*32 +: 32]};
            acc_in[i]  = '0;
         end
      end else if (busy_ff) begin
         alpha_in = alpha_ff >> 1;
         count_in = count_ff + 5'd1;
         for (int i = 0; i < Lanes; i++) begin
            // add the weighted partial product at the top, shift right one
            acc_in[i] = (acc_ff[i] + (alpha_ff[0]
               ? $signed({diff_ff[i][32], diff_ff[i], 18'd0}) : 52'sd0)) >>> 1;
         end
         if (count_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            for (int i = 0; i < Lanes; i++) begin
               // acc_in = p * 2^1 after 17 shifts of 18-bit headroom; floor by 2^16
               result_in[i*32 +: 32] = base_ff[i] + 32'(acc_in[i] >>> 17);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      alpha_ff  <= alpha_in;
      result_ff <= result_in;
      for (int i = 0; i < Lanes; i++) begin
         diff_ff[i] <= diff_in[i];
         acc_ff[i]  <= acc_in[i];
         base_ff[i] <= base_in[i];
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign result    = result_ff;

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("blend did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("blend done while busy");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff == 5'd16 && !start) |=> done_ff)
      else $error("blend missed its end");
endmodule

// ===== design/keyframe_vector_sampler.sv =====
// keyframe_vector_sampler
// req channel carries write and sample requests; a write stores one keyframe
// (time, x, y, z, w) and gives no response, a sample gives exactly one rsp.
// csr_wr_en/csr_wr_data load keys_in_use; the user must do so only while the
// block is idle, as the block itself does not enforce it. Keyframes live in
// five rams of MAX_KEYS words with registered read.
// One request is worked on at a time. A write is stored from the idle state
// and the block stays ready for the next request. A sample checks the channel,
// scans segments (ram read, wait, compare for each), fetches the two keys (only
// the first in step mode or for a one-key channel), runs the restoring
// divider that forms alpha (one bit per cycle over 17 quotient bits), runs
// the bit-serial blend over the alpha bits and loads the response register.
// Step mode and a one-key channel skip divider and blend. Empty or out-of-range
// channels go from the channel check straight to the response register.
// The response register holds its response while rsp_ready is low; the next
// req is still taken and worked on, and it waits at the end until the
// response register is free.
// Reset clears keys_in_use and the control state; ram contents stay as they
// were and must be written before they are read.
module keyframe_vector_sampler #(
   parameter int unsigned MAX_KEYS = 1024
) (
   input  logic          clock,
   input  logic          reset,
   kvs_req_if.sink       req,
   kvs_rsp_if.source     rsp,
   input  logic          csr_wr_en,
   input  logic [10:0]   csr_wr_data
);
   localparam int unsigned AddrWidth = $clog2(MAX_KEYS);
   localparam int unsigned CntWidth  = $clog2(MAX_KEYS + 1);

   kvs_pkg::state_type state_ff, state_in;

   logic [10:0]          keys_ff;
   logic [CntWidth-1:0]  loaded;

   logic                 step_ff;
   logic [9:0]           first_ff;
   logic [10:0]          count_ff;
   logic [31:0]          t_ff;
   logic [10:0]          seg_ff, seg_in;
   logic [AddrWidth-1:0] rd_addr;
   logic [31:0]          time_rd, x_rd, y_rd, z_rd, w_rd;
   logic [31:0]          t0_ff;
   logic [4*32-1:0]      val0_ff, val1_ff;
   logic [31:0]          t1_ff;

   // divider
   logic [33:0]          rem_ff, rem_in;
   logic [32:0]          den_ff;
   logic [16:0]          quot_ff, quot_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic [16:0]          alpha_val;

   logic                 blend_start;
   kvs_pkg::blend_ctl_type blend_ctl;
   logic [4*32-1:0]      blend_res;

   logic                 rsp_valid_ff;
   logic [4*32-1:0]      rsp_val_ff;
   logic [9:0]           rsp_seg_ff;
   kvs_pkg::status_type  rsp_status_ff;

   logic                 wr_en;
   logic                 accept;
   logic [11:0]          end_sum;
   logic signed [32:0]   num, dur;

   assign loaded  = (32'(keys_ff) > MAX_KEYS) ? CntWidth'(MAX_KEYS) : CntWidth'(keys_ff);
   assign accept  = req.valid && req.ready;
   assign wr_en   = accept && (req.command == kvs_pkg::CMD_WRITE)
                    && (32'(req.key_index) < MAX_KEYS);
   assign end_sum = 12'(first_ff) + 12'(count_ff);
   assign num     = $signed({t_ff[31], t_ff}) - $signed({t0_ff[31], t0_ff});
   assign dur     = $signed({t1_ff[31], t1_ff}) - $signed({t0_ff[31], t0_ff});

   always_comb begin
      rd_addr = AddrWidth'(11'(first_ff) + seg_ff);
      // scan reads the segment end key; KEY0 fetches the second key
      if (state_ff == kvs_pkg::ST_SCAN_RD || state_ff == kvs_pkg::ST_SCAN_WAIT
          || state_ff == kvs_pkg::ST_KEY0) begin
         rd_addr = AddrWidth'(11'(first_ff) + seg_ff + 11'd1);
      end
   end

   kvs_ram #(.Width(32), .Depth(MAX_KEYS)) u_time (.clock, .wr_en,
      .wr_addr(AddrWidth'(req.key_index)), .wr_data(req.key_time), .rd_addr,
      .rd_data(time_rd));
   kvs_ram #(.Width(32), .Depth(MAX_KEYS)) u_x (.clock, .wr_en,
      .wr_addr(AddrWidth'(req.key_index)), .wr_data(req.key_x), .rd_addr, .rd_data(x_rd));
   kvs_ram #(.Width(32), .Depth(MAX_KEYS)) u_y (.clock, .wr_en,
      .wr_addr(AddrWidth'(req.key_index)), .wr_data(req.key_y), .rd_addr, .rd_data(y_rd));
   kvs_ram #(.Width(32), .Depth(MAX_KEYS)) u_z (.clock, .wr_en,
      .wr_addr(AddrWidth'(req.key_index)), .wr_data(req.key_z), .rd_addr, .rd_data(z_rd));
   kvs_ram #(.Width(32), .Depth(MAX_KEYS)) u_w (.clock, .wr_en,
      .wr_addr(AddrWidth'(req.key_index)), .wr_data(req.key_w), .rd_addr, .rd_data(w_rd));

   kvs_blend u_blend (.clock, .reset, .start(blend_start), .alpha(alpha_val),
      .val_a(val0_ff), .val_b(val1_ff), .ctl(blend_ctl), .result(blend_res));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kvs_pkg::ST_IDLE: begin
            if (accept && req.command == kvs_pkg::CMD_SAMPLE) begin
               state_in = kvs_pkg::ST_CHECK;
            end
         end
         kvs_pkg::ST_CHECK: begin
            priority if (count_ff == 11'd0 || 32'(end_sum) > 32'(loaded)) begin
               state_in = kvs_pkg::ST_DONE;
            end else if (count_ff == 11'd1) begin
               state_in = kvs_pkg::ST_KEY_RD;
            end else begin
               state_in = kvs_pkg::ST_SCAN_RD;
            end
         end
         kvs_pkg::ST_SCAN_RD:   state_in = kvs_pkg::ST_SCAN_WAIT;
         kvs_pkg::ST_SCAN_WAIT: state_in = kvs_pkg::ST_SCAN_CMP;
         kvs_pkg::ST_SCAN_CMP: begin
            if ($signed(t_ff) <= $signed(time_rd) || seg_ff == count_ff - 11'd2) begin
               state_in = kvs_pkg::ST_KEY_RD;
            end else begin
               state_in = kvs_pkg::ST_SCAN_RD;
            end
         end
         kvs_pkg::ST_KEY_RD:   state_in = kvs_pkg::ST_KEY_WAIT;
         kvs_pkg::ST_KEY_WAIT: state_in = kvs_pkg::ST_KEY0;
         kvs_pkg::ST_KEY0: begin
            if (step_ff || count_ff == 11'd1) begin
               state_in = kvs_pkg::ST_DONE;
            end else begin
               state_in = kvs_pkg::ST_KEY1;
            end
         end
         kvs_pkg::ST_KEY1: state_in = kvs_pkg::ST_DIV;
         kvs_pkg::ST_DIV: begin
            if (div_cnt_ff == 5'd17) begin
               state_in = kvs_pkg::ST_BLEND;
            end
         end
         kvs_pkg::ST_BLEND: begin
            if (blend_ctl.done) begin
               state_in = kvs_pkg::ST_DONE;
            end
         end
         kvs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = kvs_pkg::ST_IDLE;
            end
         end
         default: state_in = kvs_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req.ready   = (state_ff == kvs_pkg::ST_IDLE);
      blend_start = (state_ff == kvs_pkg::ST_DIV) && (div_cnt_ff == 5'd17);
      seg_in      = seg_ff;
      if (state_ff == kvs_pkg::ST_IDLE) begin
         seg_in = '0;
      end else if (state_ff == kvs_pkg::ST_SCAN_CMP && state_in == kvs_pkg::ST_SCAN_RD) begin
         seg_in = seg_ff + 11'd1;
      end
   end

   // restoring divider: alpha = floor(num * 2^16 / dur), 17 quotient bits
   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      div_cnt_in = div_cnt_ff;
      if (state_ff == kvs_pkg::ST_KEY1) begin
         rem_in     = 34'(num);
         quot_in    = '0;
         div_cnt_in = '0;
      end else if (state_ff == kvs_pkg::ST_DIV && div_cnt_ff != 5'd17) begin
         div_cnt_in = div_cnt_ff + 5'd1;
         if (div_cnt_ff != 5'd0 || 1'b1) begin
            if (rem_ff >= {1'b0, den_ff}) begin
               rem_in  = (rem_ff - {1'b0, den_ff}) << 1;
               quot_in = {quot_ff[15:0], 1'b1};
            end else begin
               rem_in  = rem_ff << 1;
               quot_in = {quot_ff[15:0], 1'b0};
            end
         end
      end
   end

   // clamp cases decided once num and dur are known
   always_comb begin
      priority if (dur <= 0 || num <= 0) begin
         alpha_val = '0;
      end else if (num >= dur) begin
         alpha_val = 17'h10000;
      end else begin
         alpha_val = quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvs_pkg::ST_IDLE;
         keys_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            keys_ff <= csr_wr_data;
         end
         if (state_ff == kvs_pkg::ST_DONE && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      seg_ff     <= seg_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      div_cnt_ff <= div_cnt_in;
      if (accept) begin
         step_ff  <= req.step_mode;
         first_ff <= req.chan_first;
         count_ff <= req.chan_count;
         t_ff     <= req.sample_time;
      end
      if (state_ff == kvs_pkg::ST_KEY0) begin
         t0_ff   <= time_rd;
         val0_ff <= {w_rd, z_rd, y_rd, x_rd};
      end
      if (state_ff == kvs_pkg::ST_KEY1) begin
         t1_ff   <= time_rd;
         val1_ff <= {w_rd, z_rd, y_rd, x_rd};
         den_ff  <= 33'($signed({time_rd[31], time_rd}) - $signed({t0_ff[31], t0_ff}));
      end
      if (state_ff == kvs_pkg::ST_DIV && div_cnt_ff == 5'd0) begin
         den_ff <= 33'(dur);
      end
      if (state_ff == kvs_pkg::ST_DONE && (!rsp_valid_ff || rsp.ready)) begin
         priority if (count_ff == 11'd0) begin
            rsp_val_ff    <= '0;
            rsp_seg_ff    <= '0;
            rsp_status_ff <= kvs_pkg::STATUS_EMPTY;
         end else if (32'(end_sum) > 32'(loaded)) begin
            rsp_val_ff    <= '0;
            rsp_seg_ff    <= '0;
            rsp_status_ff <= kvs_pkg::STATUS_RANGE;
         end else begin
            rsp_val_ff    <= (step_ff || count_ff == 11'd1) ? val0_ff : blend_res;
            rsp_seg_ff    <= seg_ff[9:0];
            rsp_status_ff <= kvs_pkg::STATUS_OK;
         end
      end
   end

   // the key-1 read: the ram address in KEY_WAIT still points at seg,
   // so KEY0 re-targets seg+1 for the next cycle
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_x         = rsp_val_ff[31:0];
   assign rsp.out_y         = rsp_val_ff[63:32];
   assign rsp.out_z         = rsp_val_ff[95:64];
   assign rsp.out_w         = rsp_val_ff[127:96];
   assign rsp.segment_found = rsp_seg_ff;
   assign rsp.status        = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("response dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == kvs_pkg::ST_IDLE))
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      blend_ctl.busy |-> (state_ff == kvs_pkg::ST_BLEND))
      else $error("blend running outside its state");
endmodule

// ===== dv/testbench.sv =====
module testbench;

   localparam int unsigned KeyCount   = 1024;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned HoldCycles = 400;

   typedef struct {
      kvs_pkg::command_type cmd;
      logic [9:0]  key_index;
      logic [31:0] key_time;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [31:0] key_w;
      logic [9:0]  chan_first;
      logic [10:0] chan_count;
      logic        step_mode;
      logic [31:0] sample_time;
   } kvs_request_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
      logic [9:0]  segment;
      kvs_pkg::status_type status;
   } sample_value_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;

   kvs_req_if req_if ();
   kvs_rsp_if rsp_if ();

   keyframe_vector_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the clip store and register
   logic [31:0] time_mem [KeyCount];
   logic [31:0] x_mem    [KeyCount];
   logic [31:0] y_mem    [KeyCount];
   logic [31:0] z_mem    [KeyCount];
   logic [31:0] w_mem    [KeyCount];
   bit          key_written [KeyCount];
   int unsigned keys_loaded;

   sample_value_type expected_samples[$];
   int unsigned   mismatch_count;
   int unsigned   cycle_count;
   int unsigned   burst_left;
   int unsigned   phase_requests;
   bit            hold_ask;
   bit            hold_started;
   int unsigned   hold_left;
   int unsigned   stall_mode;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint to_signed(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                  longint alpha);
      longint p;
      longint r;
      p = (to_signed(b) - to_signed(a)) * alpha;
      r = to_signed(a) + (p >>> 16);
      return r[31:0];
   endfunction

   function automatic sample_value_type sample_channel(kvs_request_type r);
      sample_value_type res;
      int unsigned   loaded;
      int unsigned   seg;
      int unsigned   i0;
      int unsigned   i1;
      longint        t;
      longint        t0;
      longint        dur;
      longint        num;
      longint        alpha;
      res.x = '0;
      res.y = '0;
      res.z = '0;
      res.w = '0;
      res.segment = '0;
      loaded = (keys_loaded > KeyCount) ? KeyCount : keys_loaded;
      if (r.chan_count == 0) begin
         res.status = kvs_pkg::STATUS_EMPTY;
         return res;
      end
      if (int'(r.chan_first) + int'(r.chan_count) > loaded) begin
         res.status = kvs_pkg::STATUS_RANGE;
         return res;
      end
      t = to_signed(r.sample_time);
      seg = 0;
      if (r.chan_count > 1) begin
         seg = r.chan_count - 2;
         for (int unsigned s = 0; s <= r.chan_count - 2; s++) begin
            if (t <= to_signed(time_mem[r.chan_first + s + 1])) begin
               seg = s;
               break;
            end
         end
      end
      i0 = r.chan_first + seg;
      if (r.step_mode || r.chan_count == 1) begin
         res.x = x_mem[i0];
         res.y = y_mem[i0];
         res.z = z_mem[i0];
         res.w = w_mem[i0];
      end else begin
         i1 = i0 + 1;
         t0 = to_signed(time_mem[i0]);
         dur = to_signed(time_mem[i1]) - t0;
         num = t - t0;
         if (dur <= 0 || num <= 0) alpha = 0;
         else if (num >= dur) alpha = 65536;
         else alpha = (num * 65536) / dur;
         res.x = lerp_component(x_mem[i0], x_mem[i1], alpha);
         res.y = lerp_component(y_mem[i0], y_mem[i1], alpha);
         res.z = lerp_component(z_mem[i0], z_mem[i1], alpha);
         res.w = lerp_component(w_mem[i0], w_mem[i1], alpha);
      end
      res.segment = seg[9:0];
      res.status = kvs_pkg::STATUS_OK;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // response checker
   always @(posedge clock) begin
      sample_value_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected response", {30'd0, rsp_if.status}, 32'd0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_if.out_x !== want.x) report_mismatch("out_x", rsp_if.out_x, want.x);
            if (rsp_if.out_y !== want.y) report_mismatch("out_y", rsp_if.out_y, want.y);
            if (rsp_if.out_z !== want.z) report_mismatch("out_z", rsp_if.out_z, want.z);
            if (rsp_if.out_w !== want.w) report_mismatch("out_w", rsp_if.out_w, want.w);
            if (rsp_if.segment_found !== want.segment)
               report_mismatch("segment_found", {22'd0, rsp_if.segment_found},
                               {22'd0, want.segment});
            if (rsp_if.status !== want.status)
               report_mismatch("status", {30'd0, rsp_if.status}, {30'd0, want.status});
         end
      end
   end

   // response stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_ask && !hold_started) begin
         hold_started = 1'b1;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_if.ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_if.ready <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_request(kvs_request_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.command     <= r.cmd;
      req_if.key_index   <= r.key_index;
      req_if.key_time    <= r.key_time;
      req_if.key_x       <= r.key_x;
      req_if.key_y       <= r.key_y;
      req_if.key_z       <= r.key_z;
      req_if.key_w       <= r.key_w;
      req_if.chan_first  <= r.chan_first;
      req_if.chan_count  <= r.chan_count;
      req_if.step_mode   <= r.step_mode;
      req_if.sample_time <= r.sample_time;
      do @(posedge clock); while (!req_if.ready);
      phase_requests++;
      if (r.cmd == kvs_pkg::CMD_WRITE) begin
         time_mem[r.key_index] = r.key_time;
         x_mem[r.key_index] = r.key_x;
         y_mem[r.key_index] = r.key_y;
         z_mem[r.key_index] = r.key_z;
         w_mem[r.key_index] = r.key_w;
         key_written[r.key_index] = 1'b1;
      end else begin
         expected_samples.push_back(sample_channel(r));
      end
   endtask

   task automatic write_key(int unsigned idx, logic [31:0] t, logic [31:0] x,
                            logic [31:0] y, logic [31:0] z, logic [31:0] w);
      kvs_request_type r;
      r = '{cmd: kvs_pkg::CMD_WRITE, key_index: idx[9:0], key_time: t, key_x: x,
            key_y: y, key_z: z, key_w: w, chan_first: 10'($urandom),
            chan_count: 11'($urandom), step_mode: 1'($urandom),
            sample_time: $urandom};
      send_request(r);
   endtask

   task automatic sample_key(int unsigned first, int unsigned count, bit step,
                             logic [31:0] t);
      kvs_request_type r;
      r = '{cmd: kvs_pkg::CMD_SAMPLE, key_index: 10'($urandom), key_time: $urandom,
            key_x: $urandom, key_y: $urandom, key_z: $urandom, key_w: $urandom,
            chan_first: first[9:0], chan_count: count[10:0], step_mode: step,
            sample_time: t};
      send_request(r);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      // a trailing write may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic set_keys_in_use(int unsigned v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[10:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      keys_loaded = v;
   endtask

   task automatic sample_written_run();
      int unsigned first;
      int unsigned n;
      int unsigned count;
      int unsigned k;
      longint      lo;
      longint      hi;
      longint      t;
      first = $urandom_range(0, KeyCount - 1);
      n = 0;
      while (!key_written[first] && n < KeyCount) begin
         first = (first + 1) % KeyCount;
         n++;
      end
      if (!key_written[first]) return;
      n = 1;
      while (first + n < KeyCount && key_written[first + n] && n < 16) n++;
      count = $urandom_range(1, n);
      lo = to_signed(time_mem[first]);
      hi = to_signed(time_mem[first + count - 1]);
      case ($urandom_range(0, 7))
         0: t = longint'($signed($urandom));
         1, 2: begin
            k = first + $urandom_range(0, count - 1);
            t = to_signed(time_mem[k]);
         end
         default: begin
            if (hi >= lo)
               t = lo - 65536 + ((longint'($urandom) * (hi - lo + 131072)) >>> 32);
            else
               t = longint'($signed($urandom));
         end
      endcase
      sample_key(first, count, $urandom_range(0, 3) == 0, t[31:0]);
   endtask

   task automatic build_channel();
      int unsigned len;
      int unsigned first;
      longint      t;
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
      first = $urandom_range(0, KeyCount - len);
      t = $urandom_range(0, 32'h7fff_ffff) - 64'sh4000_0000;
      for (int unsigned i = 0; i < len; i++) begin
         write_key(first + i, t[31:0], $urandom, $urandom, $urandom, $urandom);
         case ($urandom_range(0, 7))
            0: t = t;
            1: t = t + $urandom_range(1, 32'h0100_0000);
            default: t = t + $urandom_range(1, 32'h0004_0000);
         endcase
      end
      repeat ($urandom_range(1, 4)) sample_written_run();
   endtask

   task automatic random_request();
      int unsigned pick;
      int unsigned loaded;
      int unsigned first;
      int unsigned min_count;
      pick = $urandom_range(0, 99);
      loaded = (keys_loaded > KeyCount) ? KeyCount : keys_loaded;
      if (pick < 45) begin
         build_channel();
      end else if (pick < 75) begin
         sample_written_run();
      end else if (pick < 85) begin
         write_key($urandom_range(0, KeyCount - 1), $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      end else if (pick < 93) begin
         // channel past the loaded keys, never read
         first = $urandom_range(0, KeyCount - 1);
         min_count = (loaded > first) ? loaded - first + 1 : 1;
         sample_key(first, $urandom_range(min_count, 2047), 1'($urandom), $urandom);
      end else begin
         sample_key($urandom_range(0, KeyCount - 1), 0, 1'($urandom), $urandom);
      end
   endtask

   task automatic test_directed();
      set_keys_in_use(KeyCount);
      write_key(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff);
      write_key(1, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h0);
      write_key(2, 32'h0, $urandom, $urandom, $urandom, $urandom);
      write_key(3, 32'h0004_0000, $urandom, $urandom, $urandom, $urandom);
      write_key(4, 32'h0002_0000, $urandom, $urandom, $urandom, $urandom);
      write_key(5, 32'h7fff_ffff, $urandom, $urandom, $urandom, $urandom);
      write_key(1023, $urandom, $urandom, $urandom, $urandom, $urandom);
      sample_key(0, 6, 1'b0, 32'h8000_0000);
      sample_key(0, 6, 1'b0, 32'h7fff_ffff);
      sample_key(0, 6, 1'b0, 32'hffff_0000);
      sample_key(0, 6, 1'b0, 32'h0);
      sample_key(1, 2, 1'b0, 32'h0);           // zero duration
      sample_key(0, 6, 1'b0, 32'h0003_0000);   // stops at the segment before the backwards one
      sample_key(0, 2, 1'b0, 32'hc000_1234);
      sample_key(0, 6, 1'b1, 32'h0001_0000);
      sample_key(1023, 1, 1'b0, $urandom);
      sample_key(5, 0, 1'b0, $urandom);        // empty channel
      sample_key(1023, 2, 1'b0, $urandom);     // past the loaded keys
      sample_key(0, 1024, 1'b1, $urandom);
      set_keys_in_use(2047);
      sample_key(0, 6, 1'b0, 32'h0001_8000);
      set_keys_in_use(0);
      sample_key(0, 1, 1'b0, $urandom);
      sample_key(0, 0, 1'b1, $urandom);
   endtask

   task automatic test_random_clip();
      int unsigned settings [5];
      settings = '{KeyCount, $urandom_range(1, 1023), 2047, $urandom_range(900, 1023),
                   KeyCount};
      foreach (settings[i]) begin
         set_keys_in_use(settings[i]);
         phase_requests = 0;
         while (phase_requests < 95) random_request();
      end
   endtask

   task automatic test_response_hold();
      set_keys_in_use(KeyCount);
      hold_ask = 1'b1;
      phase_requests = 0;
      while (phase_requests < 40) random_request();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.command = kvs_pkg::CMD_WRITE;
      req_if.key_index = '0;
      req_if.key_time = '0;
      req_if.key_x = '0;
      req_if.key_y = '0;
      req_if.key_z = '0;
      req_if.key_w = '0;
      req_if.chan_first = '0;
      req_if.chan_count = '0;
      req_if.step_mode = 1'b0;
      req_if.sample_time = '0;
      rsp_if.ready = 1'b0;
      keys_loaded = 0;
      mismatch_count = 0;
      cycle_count = 0;
      burst_left = 0;
      hold_ask = 1'b0;
      hold_started = 1'b0;
      hold_left = 0;
      stall_mode = 0;
      foreach (key_written[i]) key_written[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_clip();
      test_response_hold();
      wait_idle();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== keyframe_vector_sampler.f =====
design/kvs_pkg.sv
design/kvs_req_if.sv
design/kvs_rsp_if.sv
design/kvs_ram.sv
design/kvs_blend.sv
design/keyframe_vector_sampler.sv
dv/testbench.sv
